FILE: rtl/core/pimtp_pkg.sv
// ----------------------------------------------------------------------------
// pimtp_pkg
// Shared types and constants for the soil moisture PI controller and its
// time-proportional pump drive.
// ----------------------------------------------------------------------------
package pimtp_pkg;

    localparam int ADC_W  = 10;
    localparam int FRAC_W = 16;
    localparam int INTEG_W = 30;
    localparam int DIV_W  = 34;

    // Upper bound of the integral: ten seconds of full-scale error, in
    // fraction-milliseconds.
    localparam logic [INTEG_W-1:0] INTEG_MAX = 30'd655360000;
    localparam logic [FRAC_W-1:0]  DUTY_FULL = 16'hFFFF;
    localparam logic [9:0]         MS_PER_S  = 10'd1000;

    // Scaled command (already shifted down by 4096) at and above which the
    // duty saturates: 65536 * 1000.
    localparam logic [DIV_W-1:0]   CMD_SAT   = 34'd65536000;
    // ceil(2^36 / 1000); exact floor division by 1000 for inputs below 2^26.
    localparam logic [26:0]        RECIP_1K  = 27'd68719477;

    // Register indexes on the configuration port.
    localparam logic [3:0] CFG_ADC_DRY   = 4'd0;
    localparam logic [3:0] CFG_ADC_WET   = 4'd1;
    localparam logic [3:0] CFG_MOIST_MAX = 4'd2;
    localparam logic [3:0] CFG_SETPOINT  = 4'd3;
    localparam logic [3:0] CFG_GAIN_P    = 4'd4;
    localparam logic [3:0] CFG_GAIN_I    = 4'd5;
    localparam logic [3:0] CFG_WINDOW    = 4'd6;
    localparam logic [3:0] CFG_PERIOD    = 4'd7;

    typedef struct packed {
        logic [ADC_W-1:0]  adc_dry;
        logic [ADC_W-1:0]  adc_wet;
        logic [FRAC_W-1:0] moisture_max;
        logic [FRAC_W-1:0] setpoint;
        logic [FRAC_W-1:0] gain_p;
        logic [FRAC_W-1:0] gain_i;
        logic [FRAC_W-1:0] window_ms;
        logic [FRAC_W-1:0] period_ms;
    } cfg_t;

    // One tick as it travels from the front end to the back end.
    typedef struct packed {
        logic [ADC_W-1:0] adc;
        logic             upd;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOIST,
        ST_DIV1,
        ST_ERR,
        ST_MUL1,
        ST_INT,
        ST_MUL2,
        ST_SUM,
        ST_DIV2,
        ST_PWM,
        ST_OUT
    } back_state_t;

endpackage

FILE: rtl/core/pimtp_div.sv
// ----------------------------------------------------------------------------
// pimtp_div
// Restoring divider, one quotient bit per cycle, for a 34-bit dividend and
// a 10-bit divisor.
// ----------------------------------------------------------------------------
module pimtp_div
    import pimtp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [9:0]       divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0] dvd_reg;
    logic [9:0]       dsr_reg;
    logic [9:0]       rem_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [10:0]      rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? 10'(rem_sh - {1'b0, dsr_reg}) : rem_sh[9:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: rtl/core/pimtp_front.sv
// ----------------------------------------------------------------------------
// pimtp_front
// Takes in ticks and marks the ones on which the PI update runs.
// ----------------------------------------------------------------------------
module pimtp_front
    import pimtp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ADC_W-1:0]  adc_sample,
    input  logic              q_full,
    input  logic [FRAC_W-1:0] period_ms,
    output logic              in_stall,
    output logic              q_push,
    output item_t             q_item
);

    logic [FRAC_W-1:0] period_count_reg;
    logic [FRAC_W-1:0] per;
    logic [FRAC_W:0]   cnt_inc;
    logic              upd;

    assign per      = (period_ms == '0) ? 16'd1 : period_ms;
    assign cnt_inc  = {1'b0, period_count_reg} + 17'd1;
    assign upd      = cnt_inc >= {1'b0, per};
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_item   = '{adc: adc_sample, upd: upd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= '0;
        end
        else if (q_push)
        begin
            period_count_reg <= upd ? '0 : cnt_inc[FRAC_W-1:0];
        end
    end

endmodule

FILE: rtl/core/pimtp_queue.sv
// ----------------------------------------------------------------------------
// pimtp_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pimtp_queue
    import pimtp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output item_t head
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/pimtp_back.sv
// ----------------------------------------------------------------------------
// pimtp_back
// Runs the PI update on update ticks, using the divider, then advances
// the PWM window and the pump-on counter and loads the result register.
// ----------------------------------------------------------------------------
module pimtp_back
    import pimtp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  item_t             q_head,
    output logic              q_pop,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              pump_on,
    output logic [FRAC_W-1:0] duty,
    output logic              pi_updated,
    output logic [31:0]       pump_time_ms
);

    back_state_t state_reg;
    back_state_t state_next;

    item_t                    item_reg;
    logic [FRAC_W-1:0]        moist_reg;
    logic signed [16:0]       err_reg;
    logic signed [33:0]       eper_reg;
    logic signed [33:0]       pterm_reg;
    logic signed [47:0]       pterm1k_reg;
    logic [45:0]              iterm_reg;
    logic [DIV_W-1:0]         scaled_reg;
    logic [INTEG_W-1:0]       integ_reg;
    logic [FRAC_W-1:0]        duty_reg;
    logic [FRAC_W-1:0]        duty_out_reg;
    logic [31:0]              onprod_reg;
    logic [FRAC_W-1:0]        window_pos_reg;
    logic [31:0]              pump_total_reg;
    logic                     out_valid_reg;
    logic                     pump_on_reg;
    logic                     upd_out_reg;

    logic signed [10:0] num_raw;
    logic signed [10:0] den_raw;
    logic signed [10:0] num;
    logic signed [10:0] den;
    logic               moist_zero;
    logic               moist_full;
    logic [FRAC_W-1:0]  per;
    logic [FRAC_W-1:0]  win;
    logic signed [35:0] acc;
    logic signed [47:0] cmd;
    logic [52:0]        recip_prod;
    logic [FRAC_W-1:0]  on_ticks;
    logic [FRAC_W:0]    pos_inc;
    logic               pump_now;
    logic               out_free;

    logic             div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [9:0]       div_dsr;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_q;

    assign per = (cfg.period_ms == '0) ? 16'd1 : cfg.period_ms;
    assign win = (cfg.window_ms == '0) ? 16'd1 : cfg.window_ms;

    assign num_raw    = $signed({1'b0, cfg.adc_dry}) - $signed({1'b0, item_reg.adc});
    assign den_raw    = $signed({1'b0, cfg.adc_dry}) - $signed({1'b0, cfg.adc_wet});
    assign num        = (den_raw < 0) ? -num_raw : num_raw;
    assign den        = (den_raw < 0) ? -den_raw : den_raw;
    assign moist_zero = (den == 0) || (num <= 0);
    assign moist_full = num >= den;

    assign acc = 36'(signed'({6'b0, integ_reg})) + 36'(eper_reg);
    assign cmd = pterm1k_reg + $signed({2'b0, iterm_reg});

    // Division of the scaled command by 1000 by reciprocal multiplication;
    // only used when the scaled command is below the saturation point.
    assign recip_prod = scaled_reg[25:0] * RECIP_1K;

    assign on_ticks = (duty_reg == DUTY_FULL) ? win : onprod_reg[31:16];
    assign pump_now = window_pos_reg < on_ticks;
    assign pos_inc  = {1'b0, window_pos_reg} + 17'd1;
    assign out_free = !out_valid_reg || !out_stall;

    pimtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_head.upd ? ST_MOIST : ST_PWM;
                end
            end
            ST_MOIST: state_next = (moist_zero || moist_full) ? ST_ERR : ST_DIV1;
            ST_DIV1:  state_next = div_done ? ST_ERR : ST_DIV1;
            ST_ERR:   state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_INT;
            ST_INT:   state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_SUM;
            ST_SUM:   state_next = (cmd <= 0) ? ST_PWM : ST_DIV2;
            ST_DIV2:  state_next = ST_PWM;
            ST_PWM:   state_next = ST_OUT;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_MOIST:
            begin
                div_start = !(moist_zero || moist_full);
                div_dvd   = DIV_W'(num[9:0] * cfg.moisture_max);
                div_dsr   = den[9:0];
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            integ_reg      <= '0;
            duty_reg       <= '0;
            window_pos_reg <= '0;
            pump_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INT:
                begin
                    if (acc < 0)
                    begin
                        integ_reg <= '0;
                    end
                    else if (acc > $signed({6'b0, INTEG_MAX}))
                    begin
                        integ_reg <= INTEG_MAX;
                    end
                    else
                    begin
                        integ_reg <= acc[INTEG_W-1:0];
                    end
                end
                ST_SUM:
                begin
                    if (cmd <= 0)
                    begin
                        duty_reg <= '0;
                    end
                end
                ST_DIV2:
                begin
                    duty_reg <= (scaled_reg >= CMD_SAT) ? DUTY_FULL : recip_prod[51:36];
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        window_pos_reg <= (pos_inc >= {1'b0, win}) ? '0 : pos_inc[15:0];
                        if (pump_now && pump_total_reg != 32'hFFFF_FFFF)
                        begin
                            pump_total_reg <= pump_total_reg + 32'd1;
                        end
                    end
                end
                default:
                begin
                    duty_reg <= duty_reg;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    item_reg <= q_head;
                end
            end
            ST_MOIST:
            begin
                moist_reg <= moist_zero ? '0 : cfg.moisture_max;
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    moist_reg <= div_q[15:0];
                end
            end
            ST_ERR:
            begin
                err_reg <= $signed({1'b0, cfg.setpoint}) - $signed({1'b0, moist_reg});
            end
            ST_MUL1:
            begin
                eper_reg  <= err_reg * $signed({1'b0, per});
                pterm_reg <= $signed({1'b0, cfg.gain_p}) * err_reg;
            end
            ST_INT:
            begin
                pterm1k_reg <= 48'(pterm_reg * $signed({1'b0, MS_PER_S}));
            end
            ST_MUL2:
            begin
                iterm_reg <= cfg.gain_i * integ_reg;
            end
            ST_SUM:
            begin
                // The command is positive here whenever it is used, so its
                // low twelve bits carry the division by 4096.
                scaled_reg <= cmd[45:12];
            end
            ST_PWM:
            begin
                onprod_reg <= duty_reg * win;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    pump_on_reg  <= pump_now;
                    upd_out_reg  <= item_reg.upd;
                    duty_out_reg <= duty_reg;
                end
            end
            default:
            begin
                moist_reg <= moist_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign pump_on      = pump_on_reg;
    assign duty         = duty_out_reg;
    assign pi_updated   = upd_out_reg;
    assign pump_time_ms = pump_total_reg;

endmodule

FILE: rtl/core/pi_moisture_time_proportional_pwm.sv
// ----------------------------------------------------------------------------
// pi_moisture_time_proportional_pwm
// Soil moisture PI controller with anti-windup driving a pump relay by
// time-proportional PWM, one result transaction per millisecond tick.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  in       to block   in_valid / in_stall   adc_sample
//  out      from block out_valid / out_stall pump_on, duty, pi_updated,
//                                            pump_time_ms
//  cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick that does not run the PI update goes from the idle state straight
// to the PWM and output states. A tick that runs the update sends the
// moisture ratio through the one-bit-per-cycle divider unless it is zero
// or full scale. The scaling of the command by 4096000 is a shift plus a
// reciprocal multiplication, skipped when the command is not positive.
// The front end keeps taking ticks into a two-entry queue while the back end
// works, and the result register lets the next tick start while a result
// transaction is still held by out_stall. Reset clears all control state,
// the integral, duty, window position and pump-on counter, and loads the
// calibration registers with their defaults.
//
module pi_moisture_time_proportional_pwm
    import pimtp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ADC_W-1:0]  adc_sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              pump_on,
    output logic [FRAC_W-1:0] duty,
    output logic              pi_updated,
    output logic [31:0]       pump_time_ms,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    cfg_t  cfg_reg;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    item_t q_item;
    item_t q_head;

    // Registers may be written at any time; the user writes them only
    // while the block is idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_dry      <= 10'd574;
            cfg_reg.adc_wet      <= 10'd243;
            cfg_reg.moisture_max <= 16'd39322;
            cfg_reg.setpoint     <= 16'd32768;
            cfg_reg.gain_p       <= 16'd8192;
            cfg_reg.gain_i       <= 16'd205;
            cfg_reg.window_ms    <= 16'd3000;
            cfg_reg.period_ms    <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ADC_DRY:   cfg_reg.adc_dry      <= cfg_data[9:0];
                CFG_ADC_WET:   cfg_reg.adc_wet      <= cfg_data[9:0];
                CFG_MOIST_MAX: cfg_reg.moisture_max <= cfg_data;
                CFG_SETPOINT:  cfg_reg.setpoint     <= cfg_data;
                CFG_GAIN_P:    cfg_reg.gain_p       <= cfg_data;
                CFG_GAIN_I:    cfg_reg.gain_i       <= cfg_data;
                CFG_WINDOW:    cfg_reg.window_ms    <= cfg_data;
                CFG_PERIOD:    cfg_reg.period_ms    <= cfg_data;
                default:       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // The front end counts ticks and flags the update ticks.
    pimtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .adc_sample (adc_sample),
        .q_full     (q_full),
        .period_ms  (cfg_reg.period_ms),
        .in_stall   (in_stall),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    pimtp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The back end runs the PI math and the PWM window.
    pimtp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pump_on      (pump_on),
        .duty         (duty),
        .pi_updated   (pi_updated),
        .pump_time_ms (pump_time_ms)
    );

`ifndef SYNTH
    // The pump-on counter never moves backward from one result to the next.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (pump_time_ms >= $past(pump_time_ms)))
        else $error("pump_time_ms decreased");

    // With zero duty the relay stays off.
    a_zero_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (duty == 16'd0)) |-> !pump_on)
        else $error("pump on with zero duty");

    // A queue entry is only taken when one is present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");
`endif

endmodule

FILE: tb/sv/pi_moisture_time_proportional_pwm_chk.sv
// ============================================================================
// pi_moisture_time_proportional_pwm_chk
// Watches the tick, result and register channels of the pump controller,
// keeps its own model of the controller state and compares every result
// transaction field by field against the oldest predicted one.
// ============================================================================
module pi_moisture_time_proportional_pwm_chk
    import pimtp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [ADC_W-1:0]  adc_sample,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              pump_on,
    input  logic [FRAC_W-1:0] duty,
    input  logic              pi_updated,
    input  logic [31:0]       pump_time_ms,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [3:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                fail_count,
    output int                pending,
    output int                checked,
    output int                pi_runs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        pump;
        logic [15:0] duty;
        logic        upd;
        logic [31:0] total;
    } tick_result_t;

    tick_result_t result_fifo[$];
    cfg_t         regs;
    logic [15:0]  tick_cnt;
    logic [15:0]  win_pos;
    longint       integ;
    logic [15:0]  duty_now;
    logic [31:0]  on_total;

    function automatic longint moisture_from(logic [ADC_W-1:0] adc);
        longint num;
        longint den;
        num = longint'(regs.adc_dry) - longint'(adc);
        den = longint'(regs.adc_dry) - longint'(regs.adc_wet);
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        if (den == 0 || num <= 0)
            return 0;
        if (num >= den)
            return longint'(regs.moisture_max);
        return (num * longint'(regs.moisture_max)) / den;
    endfunction

    // Advances the controller model by one tick and returns what it reports.
    function automatic tick_result_t advance_tick(logic [ADC_W-1:0] adc);
        tick_result_t r;
        longint per;
        longint win;
        longint err;
        longint cmd;
        longint on_ticks;
        per = (regs.period_ms == 0) ? 1 : longint'(regs.period_ms);
        win = (regs.window_ms == 0) ? 1 : longint'(regs.window_ms);
        r.upd = 1'b0;
        if (longint'(tick_cnt) + 1 >= per)
        begin
            err = longint'(regs.setpoint) - moisture_from(adc);
            integ = integ + err * per;
            if (integ < 0)
                integ = 0;
            if (integ > longint'(INTEG_MAX))
                integ = longint'(INTEG_MAX);
            cmd = longint'(regs.gain_p) * err * 1000 + longint'(regs.gain_i) * integ;
            if (cmd <= 0)
                duty_now = '0;
            else
            begin
                cmd = cmd / 4096000;
                duty_now = (cmd > 65535) ? DUTY_FULL : cmd[15:0];
            end
            tick_cnt = '0;
            r.upd = 1'b1;
        end
        else
            tick_cnt = tick_cnt + 16'd1;
        if (duty_now == DUTY_FULL)
            on_ticks = win;
        else
            on_ticks = (longint'(duty_now) * win) >>> 16;
        r.pump = longint'(win_pos) < on_ticks;
        if (r.pump && on_total != 32'hFFFF_FFFF)
            on_total = on_total + 32'd1;
        win_pos = (longint'(win_pos) + 1 >= win) ? 16'd0 : win_pos + 16'd1;
        r.duty = duty_now;
        r.total = on_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        tick_result_t seen;
        if (!rst_n)
        begin
            regs.adc_dry      = 10'd574;
            regs.adc_wet      = 10'd243;
            regs.moisture_max = 16'd39322;
            regs.setpoint     = 16'd32768;
            regs.gain_p       = 16'd8192;
            regs.gain_i       = 16'd205;
            regs.window_ms    = 16'd3000;
            regs.period_ms    = 16'd1000;
            tick_cnt = '0;
            win_pos  = '0;
            integ    = 0;
            duty_now = '0;
            on_total = '0;
            result_fifo.delete();
            fail_count = 0;
            checked = 0;
            pi_runs = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ADC_DRY:   regs.adc_dry      = cfg_data[ADC_W-1:0];
                    CFG_ADC_WET:   regs.adc_wet      = cfg_data[ADC_W-1:0];
                    CFG_MOIST_MAX: regs.moisture_max = cfg_data;
                    CFG_SETPOINT:  regs.setpoint     = cfg_data;
                    CFG_GAIN_P:    regs.gain_p       = cfg_data;
                    CFG_GAIN_I:    regs.gain_i       = cfg_data;
                    CFG_WINDOW:    regs.window_ms    = cfg_data;
                    CFG_PERIOD:    regs.period_ms    = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen.pump  = pump_on;
                seen.duty  = duty;
                seen.upd   = pi_updated;
                seen.total = pump_time_ms;
                if (result_fifo.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("MISMATCH unexpected result pump=%0b duty=%0d upd=%0b total=%0d",
                                 seen.pump, seen.duty, seen.upd, seen.total);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    checked++;
                    if (seen.upd)
                        pi_runs++;
                    if (seen.pump !== want.pump || seen.duty !== want.duty ||
                        seen.upd !== want.upd || seen.total !== want.total)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("MISMATCH result %0d: exp pump=%0b duty=%0d upd=%0b total=%0d, got pump=%0b duty=%0d upd=%0b total=%0d",
                                     checked, want.pump, want.duty, want.upd, want.total,
                                     seen.pump, seen.duty, seen.upd, seen.total);
                    end
                end
            end
            if (in_valid && !in_stall)
                result_fifo.push_back(advance_tick(adc_sample));
        end
        pending = result_fifo.size();
    end

endmodule

FILE: tb/sv/pi_moisture_time_proportional_pwm_tb.sv
// ============================================================================
// pi_moisture_time_proportional_pwm_tb
// Drives ticks and register writes into the pump controller, with random
// idling on both channels, and reports the verdict of the attached checker.
// ============================================================================
module pi_moisture_time_proportional_pwm_tb;
    import pimtp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_TARGET = 950;
    localparam int CYCLE_LIMIT = 2000000;
    // We wait comfortably longer than a tick that runs the PI update needs
    // before touching the registers.
    localparam int SETTLE_CYCLES = 200;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ADC_W-1:0]  adc_sample;
    logic              out_valid;
    logic              out_stall;
    logic              pump_on;
    logic [FRAC_W-1:0] duty;
    logic              pi_updated;
    logic [31:0]       pump_time_ms;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [3:0]        cfg_index;
    logic [15:0]       cfg_data;

    int fail_count;
    int pending;
    int checked;
    int pi_runs;
    int cycle_cnt = 0;
    int ticks_sent;
    int phases_run;
    bit calm;
    bit hold_request;

    pi_moisture_time_proportional_pwm dut (.*);

    pi_moisture_time_proportional_pwm_chk chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver side. Normally it stalls in short random bursts; on request
    // it holds off once for a long stretch so that the block backs up
    // completely and has to stall the tick channel as well.
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !held)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                held = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // One tick transaction. The payload is held until the block takes it;
    // the stall is looked at on the falling edge where it is stable.
    task automatic send_tick(logic [ADC_W-1:0] adc);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= adc;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        ticks_sent++;
    endtask

    // Leaves cfg_valid high so that writes can follow back to back; the
    // caller drops it after the last one.
    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic drain_block();
        in_valid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (pending == 0)
                break;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Order: dry, wet, moisture max, setpoint, gain p, gain i, window, period.
    task automatic load_regs(logic [15:0] v [8]);
        write_reg(CFG_ADC_DRY,   v[0]);
        write_reg(CFG_ADC_WET,   v[1]);
        write_reg(CFG_MOIST_MAX, v[2]);
        write_reg(CFG_SETPOINT,  v[3]);
        write_reg(CFG_GAIN_P,    v[4]);
        write_reg(CFG_GAIN_I,    v[5]);
        write_reg(CFG_WINDOW,    v[6]);
        write_reg(CFG_PERIOD,    v[7]);
        cfg_valid <= 1'b0;
        phases_run++;
    endtask

    // Random settings lean toward short periods and windows so that PI
    // updates and window wraps happen often, with occasional extremes.
    function automatic logic [15:0] pick_16(int lo, int hi);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    initial
    begin
        logic [15:0] v [8];
        int n;
        int dry;
        in_valid = 1'b0;
        adc_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        ticks_sent = 0;
        phases_run = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: the first update is a thousand ticks away, so these
        // ticks only move the PWM window with zero duty.
        send_tick(10'd0);
        send_tick(10'h3FF);
        send_tick(10'd574);
        drain_block();

        // Update on every tick with the default calibration, across the
        // calibration points and the ends of the ADC range.
        v = '{16'd574, 16'd243, 16'd39322, 16'd32768, 16'd8192, 16'd205, 16'd4, 16'd1};
        load_regs(v);
        send_tick(10'd0);
        send_tick(10'h3FF);
        send_tick(10'd243);
        send_tick(10'd574);
        send_tick(10'd400);
        drain_block();

        // Saturated duty with zero window and zero period, which act as one.
        v = '{16'd574, 16'd243, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
        load_regs(v);
        send_tick(10'h3FF);
        send_tick(10'd0);
        send_tick(10'h2AA);
        drain_block();

        // Equal calibration points give zero moisture.
        v = '{16'd500, 16'd500, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd5, 16'd1};
        load_regs(v);
        send_tick(10'd500);
        send_tick(10'd0);
        drain_block();

        // Wet reading above the dry one.
        v = '{16'd100, 16'd900, 16'hFFFF, 16'h8000, 16'd4096, 16'd4096, 16'd3, 16'd1};
        load_regs(v);
        send_tick(10'd0);
        send_tick(10'd500);
        send_tick(10'h3FF);
        drain_block();

        // Run the counters up, then lower period and window below them.
        v = '{16'd574, 16'd243, 16'd39322, 16'hC000, 16'd8192, 16'd205, 16'd50, 16'd30};
        load_regs(v);
        repeat (6) send_tick(10'($urandom_range(0, 1023)));
        drain_block();
        v = '{16'd574, 16'd243, 16'd39322, 16'hC000, 16'd8192, 16'd205, 16'd3, 16'd2};
        load_regs(v);
        repeat (3) send_tick(10'($urandom_range(0, 1023)));
        drain_block();

        // Random phases.
        while (ticks_sent < TICK_TARGET)
        begin
            dry = $urandom_range(0, 1023);
            v[0] = 16'(dry);
            v[1] = ($urandom_range(0, 7) == 0) ? 16'(dry) : 16'($urandom_range(0, 1023));
            v[2] = pick_16(0, 65535);
            v[3] = pick_16(0, 65535);
            v[4] = pick_16(0, 65535);
            v[5] = pick_16(0, 65535);
            v[6] = pick_16(1, 40);
            v[7] = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                               : pick_16(1, 12);
            // Write the upper data bits of the dry ADC register now and then;
            // only the low ten bits are kept.
            if ($urandom_range(0, 3) == 0)
                v[0][15:10] = 6'($urandom_range(0, 63));
            load_regs(v);
            calm = (ticks_sent > TICK_TARGET - 150);
            // One phase with a long receiver hold-off while ticks keep coming.
            if (phases_run == 10)
                hold_request = 1'b1;
            n = $urandom_range(20, 45);
            repeat (n)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_tick(10'($urandom_range(0, 1023)));
                else
                    send_tick(10'($urandom_range(v[0] > 40 ? v[0] - 40 : 0,
                                                 v[0] > 983 ? 1023 : v[0] + 40)));
            end
            drain_block();
        end

        $display("Run covered %0d ticks in %0d register settings; %0d results checked, %0d with a PI update.",
                 ticks_sent, phases_run, checked, pi_runs);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pimtp_pkg.sv
rtl/core/pimtp_div.sv
rtl/core/pimtp_front.sv
rtl/core/pimtp_queue.sv
rtl/core/pimtp_back.sv
rtl/core/pi_moisture_time_proportional_pwm.sv
tb/sv/pi_moisture_time_proportional_pwm_chk.sv
tb/sv/pi_moisture_time_proportional_pwm_tb.sv
